>>> design/signed_number_to_seven_segment_digits_defines.svh
// Assertion macros shared by the checker of the seven-segment digit formatter.
`ifndef SIGNED_NUMBER_TO_SEVEN_SEGMENT_DIGITS_DEFINES_SVH
`define SIGNED_NUMBER_TO_SEVEN_SEGMENT_DIGITS_DEFINES_SVH

// Check a property at every rising clk edge outside reset.
`define SNSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clk edge, reset included.
`define SNSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/snsd_pkg.sv
// Types and constants shared by the digit formatter modules.
package snsd_pkg;

    localparam logic [7:0] CODE_BLANK = 8'h0F;
    localparam logic [7:0] CODE_DASH  = 8'h0A;
    localparam logic [7:0] CODE_POINT = 8'h80;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] RECIP_TEN   = 32'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic        group;
        logic        negative;
        logic [15:0] mag;
        logic [7:0]  point;
    } item_t;

endpackage

>>> design/snsd_front.sv
// Front end: accept a command and split the number into sign and magnitude.
module snsd_front
(
    input  logic                start,
    input  logic                full,
    input  logic                group,
    input  logic signed [15:0]  number,
    input  logic [7:0]          point_place,
    output logic                push,
    output snsd_pkg::item_t     item
);
    import snsd_pkg::*;

    logic        negative;
    logic [15:0] raw;

    always_comb
    begin
        raw           = number;
        negative      = raw[15];
        push          = start && !full;
        item.group    = group;
        item.negative = negative;
        // two's complement negate; the most negative value maps to 0x8000
        item.mag      = negative ? (16'd0 - raw) : raw;
        item.point    = point_place;
    end

endmodule

>>> design/snsd_queue.sv
// Two-entry queue between the front end and the digit sequencer.
module snsd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  snsd_pkg::item_t     item_in,
    input  logic                pop,
    output snsd_pkg::item_t     item_out,
    output logic                full,
    output logic                empty
);
    import snsd_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    always_comb
    begin
        full        = count_reg == 2'd2;
        empty       = count_reg == 2'd0;
        do_push     = push && !full;
        do_pop      = pop && !empty;
        item_out    = entry_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> design/snsd_back.sv
// Digit sequencer: one divide-by-ten step and one register write per cycle while a command is active.
module snsd_back
#(
    parameter int DIGITS_PER_GROUP = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  snsd_pkg::item_t     item,
    input  logic                empty,
    output logic                pop,
    output logic                strobe,
    output logic [3:0]          reg_address,
    output logic [7:0]          reg_value,
    output logic                last
);
    import snsd_pkg::*;

    localparam int CW = (DIGITS_PER_GROUP > 1) ? $clog2(DIGITS_PER_GROUP) : 1;

    logic          active_reg;
    logic          active_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          ended_reg;
    logic          ended_next;
    logic          dash_reg;
    logic          dash_next;
    logic [15:0]   mag_reg;
    logic [15:0]   mag_next;
    logic          group_reg;
    logic          group_next;
    logic [7:0]    point_reg;
    logic [7:0]    point_next;
    logic          strobe_reg;
    logic          strobe_next;
    logic [3:0]    addr_reg;
    logic [3:0]    addr_next;
    logic [7:0]    value_reg;
    logic [7:0]    value_next;
    logic          last_reg;
    logic          last_next;

    logic          last_step;
    logic          load;
    logic [31:0]   prod;
    logic [15:0]   quot;
    logic [15:0]   rem;
    logic [7:0]    code;
    logic [4:0]    addr_sum;

    always_comb
    begin
        last_step = active_reg && (cnt_reg == CW'(DIGITS_PER_GROUP - 1));
        load      = !empty && (!active_reg || last_step);
        pop       = load;

        prod = 32'(mag_reg) * RECIP_TEN;
        quot = 16'(prod >> RECIP_SHIFT);
        rem  = mag_reg - (quot << 3) - (quot << 1);

        active_next = active_reg;
        cnt_next    = cnt_reg;
        ended_next  = ended_reg;
        dash_next   = dash_reg;
        mag_next    = mag_reg;
        group_next  = group_reg;
        point_next  = point_reg;

        // pick the code for this place
        code = {4'd0, rem[3:0]};
        if (ended_reg)
        begin
            code      = dash_reg ? CODE_DASH : CODE_BLANK;
            dash_next = 1'b0;
        end
        else if ((mag_reg < 16'd10) && (cnt_reg != '0))
        begin
            ended_next = 1'b1;
        end
        if (point_reg == 8'(cnt_reg))
        begin
            code = code | CODE_POINT;
        end

        addr_sum = (group_reg ? 5'(DIGITS_PER_GROUP) : 5'd0) + 5'(cnt_reg) + 5'd1;

        strobe_next = active_reg;
        addr_next   = addr_sum[3:0];
        value_next  = code;
        last_next   = last_step;

        if (active_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            mag_next = quot;
            if (last_step)
            begin
                active_next = 1'b0;
            end
        end

        // take the next item in the cycle the current one finishes
        if (load)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            ended_next  = 1'b0;
            dash_next   = item.negative;
            mag_next    = item.mag;
            group_next  = item.group;
            point_next  = item.point;
        end

        strobe      = strobe_reg;
        reg_address = addr_reg;
        reg_value   = value_reg;
        last        = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            ended_reg  <= 1'b0;
            dash_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            ended_reg  <= ended_next;
            dash_reg   <= dash_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        group_reg <= group_next;
        point_reg <= point_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

endmodule

>>> design/signed_number_to_seven_segment_digits.sv
// Top level of the signed number to seven-segment digit-register formatter.
//
// Command channel: a transfer happens at a rising clk edge where start is high
// and busy is low; group, number and point_place are sampled at that edge.
// busy rises only while the two-entry command queue is full.
//
// Result channel: each command yields DIGITS_PER_GROUP digit-register writes,
// least significant digit first, one per cycle, each on reg_address and
// reg_value for exactly one cycle with strobe high. last marks the final
// write of a command. The receiver takes every write; it cannot stall.
//
// When the sequencer is idle, an accepted command is written into the queue,
// then loaded into the sequencer, which registers its first write.
// Throughput: one write per cycle; queued commands follow back to back.
//
// Reset (rst_n low, asynchronous): the queue empties, the sequencer drops
// any command in flight and strobe goes low.
module signed_number_to_seven_segment_digits
#(
    parameter int DIGITS_PER_GROUP = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                group,
    input  logic signed [15:0]  number,
    input  logic [7:0]          point_place,
    output logic                strobe,
    output logic [3:0]          reg_address,
    output logic [7:0]          reg_value,
    output logic                last
);
    import snsd_pkg::*;

    item_t front_item;
    item_t queue_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign busy = full;

    // classify: split sign and magnitude
    snsd_front u_front
    (
        .start       (start),
        .full        (full),
        .group       (group),
        .number      (number),
        .point_place (point_place),
        .push        (push),
        .item        (front_item)
    );

    // hold commands while the sequencer is working
    snsd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (queue_item),
        .full     (full),
        .empty    (empty)
    );

    // advance one digit per cycle while a command is active and drive the writes
    snsd_back #(
        .DIGITS_PER_GROUP (DIGITS_PER_GROUP)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (queue_item),
        .empty       (empty),
        .pop         (pop),
        .strobe      (strobe),
        .reg_address (reg_address),
        .reg_value   (reg_value),
        .last        (last)
    );

endmodule

>>> design/snsd_checker.sv
// Port-level checker for the digit formatter and its bind.
`include "signed_number_to_seven_segment_digits_defines.svh"

module snsd_checker
#(
    parameter int DIGITS_PER_GROUP = 4
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                strobe,
    input logic [3:0]          reg_address,
    input logic [7:0]          reg_value,
    input logic                last
);

    logic [3:0] addr_inc;
    logic [3:0] last_lo;
    logic [3:0] last_hi;
    logic       mid_burst;
    logic       last_addr_ok;
    logic       code_ok;

    assign addr_inc     = reg_address + 4'd1;
    assign last_lo      = 4'(DIGITS_PER_GROUP);
    assign last_hi      = 4'(2 * DIGITS_PER_GROUP);
    assign mid_burst    = strobe && !last;
    assign last_addr_ok = (reg_address == last_lo) || (reg_address == last_hi);
    assign code_ok      = (reg_value[6:0] <= 7'd10) || (reg_value[6:0] == 7'd15);

    `SNSD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !strobe, "strobe high after reset")
    `SNSD_ASSERT(a_last_strobe, last |-> strobe, "last without strobe")
    `SNSD_ASSERT(a_burst, mid_burst |=> strobe && (reg_address == $past(addr_inc)), "burst broken")
    `SNSD_ASSERT(a_last_addr, strobe && last |-> last_addr_ok, "bad final address")
    `SNSD_ASSERT(a_code, strobe |-> code_ok, "bad digit code")

endmodule

bind signed_number_to_seven_segment_digits snsd_checker #(
    .DIGITS_PER_GROUP (DIGITS_PER_GROUP)
) u_snsd_checker (.*);
